// ----- hdl/tcd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcd_pkg: shared types and constants of the token classifier
// Byte classes, DFA state codes, reserved word table and token codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    // One-hot DFA state codes.
    typedef enum logic [5:0] {
        ST_START = 6'b000001,
        ST_VAR   = 6'b000010,
        ST_NUM   = 6'b000100,
        ST_OPER  = 6'b001000,
        ST_SPEC  = 6'b010000,
        ST_KEYW  = 6'b100000
    } dfa_state_t;

    // Byte classes.
    typedef enum logic [2:0] {
        CLS_LETTER = 3'd0,
        CLS_DIGIT  = 3'd1,
        CLS_OPER   = 3'd2,
        CLS_SPEC   = 3'd3,
        CLS_SPACE  = 3'd4,
        CLS_JOIN   = 3'd5
    } cls_t;

    // One classified byte as it waits in the queue.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        cls_t       cls;
        logic       alpha;
    } tcd_item_t;

    // Reserved word table.
    localparam int KW_COUNT   = 10;
    localparam int KW_MAX_LEN = 7;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"P", "R", "O", "G", "R", "A", "M"},
        '{"B", "E", "G", "I", "N", 8'h00, 8'h00},
        '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"I", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "H", "E", "N", 8'h00, 8'h00, 8'h00},
        '{"E", "L", "S", "E", 8'h00, 8'h00, 8'h00},
        '{"W", "H", "I", "L", "E", 8'h00, 8'h00},
        '{"I", "N", "T", "E", "G", "E", "R"},
        '{"R", "E", "A", "L", 8'h00, 8'h00, 8'h00},
        '{"F", "L", "O", "A", "T", 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd7, 3'd5, 3'd3, 3'd2, 3'd4, 3'd4, 3'd5, 3'd7, 3'd4, 3'd5
    };

    // Token codes.
    localparam logic [9:0] TOK_VAR   = 10'd100;
    localparam logic [9:0] TOK_NUM   = 10'd200;
    localparam logic [9:0] TOK_OPER  = 10'd300;
    localparam logic [9:0] TOK_PLUS  = 10'd301;
    localparam logic [9:0] TOK_MINUS = 10'd302;
    localparam logic [9:0] TOK_LESS  = 10'd303;
    localparam logic [9:0] TOK_GREAT = 10'd304;
    localparam logic [9:0] TOK_EQUAL = 10'd305;
    localparam logic [9:0] TOK_SPEC  = 10'd400;
    localparam logic [9:0] TOK_SEMI  = 10'd401;
    localparam logic [9:0] TOK_COMMA = 10'd402;
    localparam logic [9:0] TOK_COLON = 10'd404;
    localparam logic [9:0] TOK_QUEST = 10'd405;
    localparam logic [9:0] TOK_CARET = 10'd406;
    localparam logic [9:0] TOK_KEYW  = 10'd500;
    localparam logic [9:0] TOK_NONE  = 10'd600;

    localparam logic [9:0] KW_CODE [KW_COUNT] = '{
        10'd501, 10'd502, 10'd503, 10'd504, 10'd505,
        10'd506, 10'd507, 10'd508, 10'd509, 10'd500
    };

    // Character of reserved word k at position pos.
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
        return KW_TEXT[k][pos];
    endfunction

    // True for A-Z and a-z.
    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Byte class decoder; unlisted bytes count as letters.
    function automatic cls_t classify(input logic [7:0] c);
        cls_t cls;
        unique case (c) inside
            [8'h30:8'h39]:                     cls = CLS_DIGIT;  // 0-9
            8'h2B, 8'h2D, 8'h3C, 8'h3E, 8'h3D: cls = CLS_OPER;   // + - < > =
            8'h3B, 8'h2C, 8'h3A, 8'h3F, 8'h5E: cls = CLS_SPEC;   // ; , : ? ^
            8'h20:                             cls = CLS_SPACE;
            8'h5F, 8'h25, 8'h26:               cls = CLS_JOIN;   // _ % &
            default:                           cls = CLS_LETTER;
        endcase
        return cls;
    endfunction

    // Transition table. Variable and keyword states share one row.
    function automatic dfa_state_t dfa_next(input dfa_state_t st, input cls_t cls);
        logic       in_word;
        dfa_state_t nxt;
        in_word = (st == ST_VAR) || (st == ST_KEYW);
        unique case (cls)
            CLS_LETTER: nxt = ST_VAR;
            CLS_DIGIT:  nxt = in_word ? ST_VAR : ST_NUM;
            CLS_OPER:   nxt = ST_OPER;
            CLS_SPEC:   nxt = ST_SPEC;
            CLS_SPACE:  nxt = ST_START;
            CLS_JOIN:   nxt = in_word ? ST_VAR : ST_START;
            default:    nxt = ST_START;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tcd_front.sv -----
// ----------------------------------------------------------------------------
// tcd_front: input side of the token classifier
// Accepts bytes from the input stream and classifies them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_front (
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,    // [7:0] ch
    input  wire logic              s_tlast,    // last
    input  wire logic              q_full,
    output logic                   q_push,
    output tcd_pkg::tcd_item_t     q_item
);
    import tcd_pkg::*;

    // A byte is taken whenever the queue has room.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the byte on its way into the queue.
    always_comb begin
        q_item.ch    = s_tdata;
        q_item.last  = s_tlast;
        q_item.cls   = classify(s_tdata);
        q_item.alpha = is_alpha(s_tdata);
    end

endmodule

`default_nettype wire

// ----- hdl/tcd_queue.sv -----
// ----------------------------------------------------------------------------
// tcd_queue: two-entry queue between front and back
// Lets either side stall on its own; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire tcd_pkg::tcd_item_t push_item,
    output logic                    full,
    output logic                    valid,
    output tcd_pkg::tcd_item_t      head_item,
    input  wire logic               pop
);
    import tcd_pkg::*;

    tcd_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign valid     = (count_reg != 2'd0);
    assign head_item = entry_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tcd_back.sv -----
// ----------------------------------------------------------------------------
// tcd_back: DFA and token output of the token classifier
// Steps the DFA one byte per cycle unless a word's last byte waits on the
// output; tracks reserved word prefixes; registers one token code per word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_back #(
    parameter int MAX_KEYWORD_LEN = 7
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire tcd_pkg::tcd_item_t q_item,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata    // [9:0] token_code
);
    import tcd_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEYWORD_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_KEYWORD_LEN);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_KEYWORD_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    dfa_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [KW_COUNT-1:0] kw_ok_reg, kw_ok_next;
    logic [1:0]        wlen_reg, wlen_next;
    logic [7:0]        first_reg, first_next;
    logic              all_reg, all_next;
    logic              out_valid_reg;
    logic [9:0]        out_code_reg;

    logic              kw_hit;
    logic [9:0]        kw_code;
    logic              single;
    logic [9:0]        code;

    // The last byte of a word waits until the output register is free.
    assign q_pop    = q_valid && (!q_item.last || !out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_code_reg};

    // Reserved word prefix tracking: a flag stays set while the letters seen
    // so far are a prefix of that word.
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            if (q_item.alpha) begin
                kw_ok_next[k] = kw_ok_reg[k] && (count_reg < CNT_W'(KW_LEN[k])) &&
                                (kw_char(k, count_reg[2:0]) == q_item.ch);
            end else begin
                kw_ok_next[k] = kw_ok_reg[k];
            end
        end
        if (!q_item.alpha) begin
            count_next = count_reg;
        end else if (count_reg < CNT_MAX) begin
            count_next = count_reg + CNT_ONE;
        end else begin
            count_next = CNT_OVER;
        end
        kw_hit  = 1'b0;
        kw_code = TOK_KEYW;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (kw_ok_next[k] && (count_next == CNT_W'(KW_LEN[k]))) begin
                kw_hit  = 1'b1;
                kw_code = KW_CODE[k];
            end
        end
    end

    // State step and word bookkeeping.
    always_comb begin
        state_next = kw_hit ? ST_KEYW : dfa_next(state_reg, q_item.cls);
        wlen_next  = (wlen_reg == 2'd2) ? 2'd2 : wlen_reg + 2'd1;
        first_next = (wlen_reg == 2'd0) ? q_item.ch : first_reg;
        all_next   = all_reg && q_item.alpha;
        single     = (wlen_reg == 2'd0);
    end

    // Token code of the word as it stands after this byte.
    always_comb begin
        unique case (state_next)
            ST_VAR: code = TOK_VAR;
            ST_NUM: code = TOK_NUM;
            ST_OPER: begin
                code = TOK_OPER;
                if (single) begin
                    case (first_next)
                        8'h2B:   code = TOK_PLUS;
                        8'h2D:   code = TOK_MINUS;
                        8'h3C:   code = TOK_LESS;
                        8'h3E:   code = TOK_GREAT;
                        8'h3D:   code = TOK_EQUAL;
                        default: code = TOK_OPER;
                    endcase
                end
            end
            ST_SPEC: begin
                code = TOK_SPEC;
                if (single) begin
                    case (first_next)
                        8'h3B:   code = TOK_SEMI;
                        8'h2C:   code = TOK_COMMA;
                        8'h3A:   code = TOK_COLON;
                        8'h3F:   code = TOK_QUEST;
                        8'h5E:   code = TOK_CARET;
                        default: code = TOK_SPEC;
                    endcase
                end
            end
            ST_KEYW: code = (all_next && kw_hit) ? kw_code : TOK_KEYW;
            default: code = TOK_NONE;
        endcase
    end

    // Word state: cleared after the last byte of each word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
            count_reg <= '0;
            kw_ok_reg <= '1;
            wlen_reg  <= 2'd0;
            all_reg   <= 1'b1;
        end else if (q_pop) begin
            if (q_item.last) begin
                state_reg <= ST_START;
                count_reg <= '0;
                kw_ok_reg <= '1;
                wlen_reg  <= 2'd0;
                all_reg   <= 1'b1;
            end else begin
                state_reg <= state_next;
                count_reg <= count_next;
                kw_ok_reg <= kw_ok_next;
                wlen_reg  <= wlen_next;
                all_reg   <= all_next;
            end
        end
    end

    // The first byte is only read once it has been written in the same word.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            first_reg <= first_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop && q_item.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last) begin
            out_code_reg <= code;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/token_classifier_dfa_top.sv -----
// ----------------------------------------------------------------------------
// token_classifier_dfa_top: table-driven token classifier
// Classifies words given one byte per transfer and emits one token code at
// the last byte of each word.
//
//   Channel  Dir  tdata           tuser  tlast  Transfers
//   s_       in   [7:0] ch        -      last   one per byte
//   m_       out  [9:0] code      -      -      one per word
//
// One byte per cycle is taken while the queue has room. A byte waits in the
// queue until the DFA takes it, and the token code of a word is registered
// at its last byte. The two-entry queue between the classifier and the DFA
// absorbs a stalled output; s_tready drops only when the queue is full.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module token_classifier_dfa_top #(
    parameter int MAX_KEYWORD_LEN = 7
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] ch
    input  wire logic        s_tlast,    // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata     // [9:0] token_code
);
    import tcd_pkg::*;

    logic      q_full;
    logic      q_push;
    tcd_item_t q_in;
    logic      q_valid;
    tcd_item_t q_head;
    logic      q_pop;

    tcd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    tcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .head_item (q_head),
        .pop       (q_pop)
    );

    tcd_back #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- hdl/tcd_checker.sv -----
// ----------------------------------------------------------------------------
// tcd_checker: port-level checks of the token classifier
// Watches the top level's ports and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every token code lies in the defined range and the padding is zero.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:0] >= 10'd100) && (m_tdata[9:0] <= 10'd600) &&
                     (m_tdata[15:10] == 6'd0))
        else $error("token code out of range");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // Reset empties the queue, so input is taken right away.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind token_classifier_dfa_top tcd_checker u_tcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
